/* rtl/cknn_pkg.sv */
package cknn_pkg;

   localparam int TRAIN_MAX_DEF = 1024;
   localparam int K_MAX_DEF = 15;
   localparam int ALPHABET_SIZE = 20;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int COUNT_W = 16;
   localparam logic [COUNT_W-1:0] COUNT_SAT = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_TRAIN = 2'd0,
      OP_TEST = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLASSIFIED = 2'd0,
      ST_STORED = 2'd1,
      ST_FULL = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] residue_char;
      logic class_label;
      logic last_of_sequence;
   } req_type;

   typedef struct packed {
      logic predicted_label;
      logic [3:0] votes_for_one;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_STORE,
      S_DIST,
      S_INSERT,
      S_VOTE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accum;
      logic clr_seq;
      logic clr_table;
      logic div_start;
      logic store_start;
      logic dist_start;
      logic ins_start;
      logic vote_start;
      logic vote_done;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic store_done;
      logic dist_done;
      logic ins_done;
      logic more_entries;
      logic table_full;
      logic table_empty;
      logic vote_done;
   } sts_type;

   function automatic logic [4:0] letter_code(input logic [7:0] ch);
      logic [4:0] r;
      case (ch)
         8'h41: r = 5'd0;
         8'h43: r = 5'd1;
         8'h44: r = 5'd2;
         8'h45: r = 5'd3;
         8'h46: r = 5'd4;
         8'h47: r = 5'd5;
         8'h48: r = 5'd6;
         8'h49: r = 5'd7;
         8'h4B: r = 5'd8;
         8'h4C: r = 5'd9;
         8'h4D: r = 5'd10;
         8'h4E: r = 5'd11;
         8'h50: r = 5'd12;
         8'h51: r = 5'd13;
         8'h52: r = 5'd14;
         8'h53: r = 5'd15;
         8'h54: r = 5'd16;
         8'h56: r = 5'd17;
         8'h57: r = 5'd18;
         8'h59: r = 5'd19;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

/* rtl/cknn_ctrl.sv */
module cknn_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_fire,
   input  cknn_pkg::req_type req,
   input  cknn_pkg::sts_type sts,
   output cknn_pkg::cmd_type cmd,
   output logic busy
);
   import cknn_pkg::*;

   state_type state_ff, state_in;
   logic test_ff, test_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         test_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         test_ff <= test_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      test_in = test_ff;
      cmd = '0;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req.opcode == OP_CLEAR) begin
                  cmd.clr_seq = 1'b1;
                  cmd.clr_table = 1'b1;
               end else if (req.opcode == OP_TRAIN || req.opcode == OP_TEST) begin
                  cmd.accum = 1'b1;
                  if (req.last_of_sequence) begin
                     cmd.div_start = 1'b1;
                     test_in = (req.opcode == OP_TEST);
                     state_in = S_DIV;
                  end
               end
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.clr_seq = 1'b1;
               if (!test_ff) begin
                  cmd.store_start = 1'b1;
                  state_in = S_STORE;
               end else if (sts.table_empty) begin
                  cmd.vote_start = 1'b1;
                  state_in = S_VOTE;
               end else begin
                  cmd.dist_start = 1'b1;
                  state_in = S_DIST;
               end
            end
         end
         S_STORE: begin
            if (sts.store_done) begin
               cmd.vote_start = 1'b1;
               state_in = S_VOTE;
            end
         end
         S_DIST: begin
            if (sts.dist_done) begin
               cmd.ins_start = 1'b1;
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            if (sts.ins_done) begin
               if (sts.more_entries) begin
                  cmd.dist_start = 1'b1;
                  state_in = S_DIST;
               end else begin
                  cmd.vote_start = 1'b1;
                  state_in = S_VOTE;
               end
            end
         end
         S_VOTE: begin
            if (sts.vote_done) begin
               cmd.vote_done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

/* rtl/cknn_dp.sv */
module cknn_dp #(
   parameter int TRAIN_MAX = cknn_pkg::TRAIN_MAX_DEF,
   parameter int K_MAX = cknn_pkg::K_MAX_DEF,
   parameter int FRACTION_BITS = cknn_pkg::FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  cknn_pkg::req_type req,
   input  logic [3:0] neighbor_count,
   input  cknn_pkg::cmd_type cmd,
   input  logic is_test,
   output cknn_pkg::sts_type sts,
   output logic rsp_valid,
   output cknn_pkg::rsp_type rsp
);
   import cknn_pkg::*;

   localparam int FW = FRACTION_BITS + 1;
   localparam int DW = 2 * FW + 5;
   localparam int AW = (TRAIN_MAX > 1) ? $clog2(TRAIN_MAX) : 1;
   localparam int NW = $clog2(TRAIN_MAX + 1);
   localparam int KW = $clog2(K_MAX + 1);
   localparam int LW = $clog2(ALPHABET_SIZE);
   localparam int MW = AW + LW;
   localparam int NUM_W = COUNT_W + FRACTION_BITS;

   // sequence accumulator
   logic [COUNT_W-1:0] cnt_ff [ALPHABET_SIZE];
   logic [COUNT_W-1:0] len_ff;
   logic [4:0] code;
   logic [COUNT_W-1:0] cnt0_next;

   assign code = letter_code(req.residue_char);
   assign cnt0_next = (cmd.accum && code == 5'd0 && cnt_ff[0] != COUNT_SAT)
                      ? cnt_ff[0] + 1'b1 : cnt_ff[0];

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_seq) begin
         len_ff <= '0;
         for (int i = 0; i < ALPHABET_SIZE; i++) cnt_ff[i] <= '0;
      end else if (cmd.accum) begin
         if (len_ff != COUNT_SAT) len_ff <= len_ff + 1'b1;
         for (int i = 0; i < ALPHABET_SIZE; i++)
            if (code == 5'(i) && cnt_ff[i] != COUNT_SAT) cnt_ff[i] <= cnt_ff[i] + 1'b1;
      end
   end

   // restoring divider, one quotient bit a cycle, one letter after another
   logic [LW-1:0] dl_ff, dl_in;
   logic [NUM_W-1:0] num_ff;
   logic [COUNT_W:0] rem_ff;
   logic [FW-1:0] quo_ff;
   logic [$clog2(NUM_W+1)-1:0] bit_ff;
   logic div_run_ff, div_done_ff;
   logic [FW-1:0] feat_ff [ALPHABET_SIZE];
   logic [COUNT_W:0] rem_sh;
   logic ge;

   assign rem_sh = {rem_ff[COUNT_W-1:0], num_ff[NUM_W-1]};
   assign ge = rem_sh >= {1'b0, len_ff};
   assign dl_in = dl_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff <= 1'b0;
         div_done_ff <= 1'b0;
      end else begin
         div_done_ff <= 1'b0;
         if (cmd.div_start) begin
            div_run_ff <= 1'b1;
            dl_ff <= '0;
            bit_ff <= '0;
            rem_ff <= '0;
            num_ff <= {cnt0_next, {FRACTION_BITS{1'b0}}};
         end else if (div_run_ff) begin
            rem_ff <= ge ? rem_sh - {1'b0, len_ff} : rem_sh;
            quo_ff <= {quo_ff[FW-2:0], ge};
            num_ff <= num_ff << 1;
            if (bit_ff == ($clog2(NUM_W+1))'(NUM_W - 1)) begin
               feat_ff[dl_ff] <= {quo_ff[FW-2:0], ge};
               bit_ff <= '0;
               rem_ff <= '0;
               if (dl_ff == LW'(ALPHABET_SIZE - 1)) begin
                  div_run_ff <= 1'b0;
                  div_done_ff <= 1'b1;
               end else begin
                  dl_ff <= dl_in;
                  num_ff <= {cnt_ff[dl_in], {FRACTION_BITS{1'b0}}};
               end
            end else begin
               bit_ff <= bit_ff + 1'b1;
            end
         end
      end
   end

   // label is taken on the last residue, held here
   logic lab_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_start) lab_ff <= req.class_label;
   end

   // training table, one feature word a cycle
   logic [FW-1:0] fmem [TRAIN_MAX * ALPHABET_SIZE];
   logic lmem [TRAIN_MAX];
   logic [NW-1:0] stored_ff;
   logic [NW-1:0] ent_ff;
   logic [LW-1:0] wl_ff;
   logic st_run_ff, st_done_ff;
   logic [MW-1:0] base;
   logic [MW-1:0] rd_addr;
   logic [FW-1:0] rd_q;
   logic rd_lab_q;
   logic full;

   assign full = (stored_ff == NW'(TRAIN_MAX));
   assign base = MW'(stored_ff[AW-1:0]) * MW'(ALPHABET_SIZE);

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_table) begin
         stored_ff <= '0;
         st_run_ff <= 1'b0;
         st_done_ff <= 1'b0;
      end else begin
         st_done_ff <= 1'b0;
         if (cmd.store_start) begin
            if (full) st_done_ff <= 1'b1;
            else begin
               st_run_ff <= 1'b1;
               wl_ff <= '0;
               lmem[stored_ff[AW-1:0]] <= lab_ff;
            end
         end else if (st_run_ff) begin
            fmem[base + MW'(wl_ff)] <= feat_ff[wl_ff];
            wl_ff <= wl_ff + 1'b1;
            if (wl_ff == LW'(ALPHABET_SIZE - 1)) begin
               st_run_ff <= 1'b0;
               st_done_ff <= 1'b1;
               stored_ff <= stored_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_q <= fmem[rd_addr];
      rd_lab_q <= lmem[ent_ff[AW-1:0]];
   end

   // distance: square stage then accumulate
   logic [LW-1:0] rl_ff;
   logic [LW:0] acc_n_ff;
   logic rd_v_ff, sq_v_ff, dist_run_ff, dist_done_ff;
   logic [LW-1:0] rl_q_ff;
   logic [FW-1:0] diff;
   logic [2*FW-1:0] sq_ff;
   logic [DW-1:0] dist_ff;

   assign rd_addr = MW'(ent_ff[AW-1:0]) * MW'(ALPHABET_SIZE) + MW'(rl_ff);
   assign diff = (rd_q >= feat_ff[rl_q_ff]) ? rd_q - feat_ff[rl_q_ff]
                                            : feat_ff[rl_q_ff] - rd_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_run_ff <= 1'b0;
         dist_done_ff <= 1'b0;
         rd_v_ff <= 1'b0;
         sq_v_ff <= 1'b0;
      end else begin
         dist_done_ff <= 1'b0;
         rd_v_ff <= 1'b0;
         sq_v_ff <= rd_v_ff;
         if (cmd.dist_start) begin
            dist_run_ff <= 1'b1;
            rl_ff <= '0;
            acc_n_ff <= '0;
            dist_ff <= '0;
         end else if (dist_run_ff) begin
            if (rl_ff != LW'(ALPHABET_SIZE - 1) || !rd_v_ff) begin
               // issue reads
            end
            if (acc_n_ff == '0 && !rd_v_ff && !sq_v_ff && rl_ff == '0) begin
               rd_v_ff <= 1'b1;
               rl_q_ff <= rl_ff;
               rl_ff <= rl_ff + 1'b1;
            end else if (rd_v_ff && rl_q_ff != LW'(ALPHABET_SIZE - 1)) begin
               rd_v_ff <= 1'b1;
               rl_q_ff <= rl_ff;
               rl_ff <= rl_ff + 1'b1;
            end
            if (rd_v_ff) sq_ff <= diff * diff;
            if (sq_v_ff) begin
               dist_ff <= dist_ff + DW'(sq_ff);
               acc_n_ff <= acc_n_ff + 1'b1;
               if (acc_n_ff == (LW+1)'(ALPHABET_SIZE - 1)) begin
                  dist_run_ff <= 1'b0;
                  dist_done_ff <= 1'b1;
               end
            end
         end
      end
   end

   // k list, one shift slot per cycle
   logic [DW-1:0] bd_ff [K_MAX];
   logic bl_ff [K_MAX];
   logic [KW-1:0] k_ff, filled_ff, pos_ff;
   logic ins_run_ff, ins_done_ff;
   logic [KW-1:0] kc;
   logic [KW-1:0] kcap;
   logic cur_lab_ff;
   logic before_pos, before_last;

   assign kcap = (neighbor_count == 4'd0) ? KW'(1) :
                 (32'(neighbor_count) > K_MAX) ? KW'(K_MAX) : KW'(neighbor_count);
   assign kc = (32'(kcap) > 32'(stored_ff)) ? KW'(stored_ff) : kcap;
   assign before_pos = (pos_ff != '0) &&
      ((dist_ff < bd_ff[pos_ff - 1'b1]) ||
       (dist_ff == bd_ff[pos_ff - 1'b1] && !cur_lab_ff && bl_ff[pos_ff - 1'b1]));
   assign before_last = (dist_ff < bd_ff[k_ff - 1'b1]) ||
       (dist_ff == bd_ff[k_ff - 1'b1] && !cur_lab_ff && bl_ff[k_ff - 1'b1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_run_ff <= 1'b0;
         ins_done_ff <= 1'b0;
      end else begin
         ins_done_ff <= 1'b0;
         if (cmd.div_start) begin
            ent_ff <= '0;
            filled_ff <= '0;
         end
         if (dist_run_ff) cur_lab_ff <= rd_lab_q;
         if (is_test && cmd.div_start == 1'b0 && !dist_run_ff && !ins_run_ff)
            k_ff <= kc;
         if (cmd.ins_start) begin
            if (filled_ff == k_ff && !before_last) begin
               ins_done_ff <= 1'b1;
               ent_ff <= ent_ff + 1'b1;
            end else begin
               ins_run_ff <= 1'b1;
               pos_ff <= (filled_ff < k_ff) ? filled_ff : k_ff - 1'b1;
            end
         end else if (ins_run_ff) begin
            if (before_pos) begin
               bd_ff[pos_ff] <= bd_ff[pos_ff - 1'b1];
               bl_ff[pos_ff] <= bl_ff[pos_ff - 1'b1];
               pos_ff <= pos_ff - 1'b1;
            end else begin
               bd_ff[pos_ff] <= dist_ff;
               bl_ff[pos_ff] <= cur_lab_ff;
               if (filled_ff < k_ff) filled_ff <= filled_ff + 1'b1;
               ins_run_ff <= 1'b0;
               ins_done_ff <= 1'b1;
               ent_ff <= ent_ff + 1'b1;
            end
         end
      end
   end

   // vote count over the k slots
   logic [KW-1:0] vi_ff;
   logic [3:0] votes_ff;
   logic vote_run_ff, vote_done_ff;
   logic [1:0] stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vote_run_ff <= 1'b0;
         vote_done_ff <= 1'b0;
      end else begin
         vote_done_ff <= 1'b0;
         if (cmd.vote_start) begin
            votes_ff <= '0;
            vi_ff <= '0;
            if (!is_test) begin
               stat_ff <= full ? ST_FULL : ST_STORED;
               vote_done_ff <= 1'b1;
            end else if (stored_ff == '0) begin
               stat_ff <= ST_EMPTY;
               vote_done_ff <= 1'b1;
            end else begin
               stat_ff <= ST_CLASSIFIED;
               vote_run_ff <= 1'b1;
            end
         end else if (vote_run_ff) begin
            votes_ff <= votes_ff + 4'(bl_ff[vi_ff]);
            vi_ff <= vi_ff + 1'b1;
            if (vi_ff == k_ff - 1'b1) begin
               vote_run_ff <= 1'b0;
               vote_done_ff <= 1'b1;
            end
         end
      end
   end

   // stored result held for the store case: full flag captured before increment
   logic was_full_ff;
   always_ff @(posedge clock) begin
      if (cmd.store_start) was_full_ff <= full;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= cmd.vote_done;
      if (cmd.vote_done) begin
         rsp.status <= (stat_ff == ST_FULL || stat_ff == ST_STORED)
                       ? (was_full_ff ? ST_FULL : ST_STORED) : stat_ff;
         rsp.votes_for_one <= (stat_ff == ST_CLASSIFIED) ? votes_ff : 4'd0;
         rsp.predicted_label <= (stat_ff == ST_CLASSIFIED) &&
                                ({votes_ff, 1'b0} > 5'(k_ff));
      end
   end

   assign sts.div_done = div_done_ff;
   assign sts.store_done = st_done_ff;
   assign sts.dist_done = dist_done_ff;
   assign sts.ins_done = ins_done_ff;
   assign sts.more_entries = (ent_ff < stored_ff);
   assign sts.table_full = full;
   assign sts.table_empty = (stored_ff == '0);
   assign sts.vote_done = vote_done_ff;
endmodule

/* rtl/composition_knn_classifier.sv */
// Amino-acid composition k-nearest-neighbour classifier. Residues are taken one per
// cycle while busy is low. On the last residue of a sequence the block goes busy:
// twenty serial divisions build the feature vector, a training sequence then
// writes it unless the table is full, and a test sequence walks every stored entry
// (distance work plus insertion into the k list for each) and counts k votes. The
// result then shows for one cycle on rsp_valid; rsp_data holds it until the next.
module composition_knn_classifier #(
   parameter int TRAIN_MAX = cknn_pkg::TRAIN_MAX_DEF,
   parameter int K_MAX = cknn_pkg::K_MAX_DEF,
   parameter int FRACTION_BITS = cknn_pkg::FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  cknn_pkg::req_type req_data,
   output logic rsp_valid,
   output cknn_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic [3:0] csr_wdata
);
   import cknn_pkg::*;

   logic [3:0] k_reg_ff;
   logic test_ff;
   cmd_type cmd;
   sts_type sts;
   logic fire;

   assign fire = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) k_reg_ff <= 4'd1;
      else if (csr_we) k_reg_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) test_ff <= 1'b0;
      else if (cmd.div_start) test_ff <= (req_data.opcode == OP_TEST);
   end

   cknn_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(fire), .req(req_data),
      .sts(sts), .cmd(cmd), .busy(busy)
   );

   cknn_dp #(.TRAIN_MAX(TRAIN_MAX), .K_MAX(K_MAX), .FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .neighbor_count(k_reg_ff),
      .cmd(cmd), .is_test(test_ff), .sts(sts), .rsp_valid(rsp_valid),
      .rsp(rsp_data)
   );

`ifndef SYNTHESIS
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without request");
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
   a_vote_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_CLASSIFIED |-> rsp_data.votes_for_one == 4'd0)
      else $error("votes on non classified result");
`endif
endmodule
